@@ design/nndm_pkg.sv @@
// package for the nearest neighbor demosaic: widths, register codes, mosaic color map
// no dependencies
package nndm_pkg;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int PIX_BITS        = 16;
    localparam int PATTERN_BITS    = 3;
    localparam int LINE_WIDTH_BITS = 13;
    localparam int MIN_WIDTH       = 2;
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;

    localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 13'd640;

    typedef enum logic {
        REG_PATTERN    = 1'b0,
        REG_LINE_WIDTH = 1'b1
    } t_reg_sel;

    typedef enum logic [2:0] {
        COL_R = 3'd0,
        COL_G = 3'd1,
        COL_B = 3'd2,
        COL_C = 3'd3,
        COL_M = 3'd4,
        COL_Y = 3'd5
    } t_color;

    // color at window position {row parity, column parity}
    localparam t_color PATTERN_MAP [8][4] = '{
        '{COL_R, COL_G, COL_G, COL_B},
        '{COL_B, COL_G, COL_G, COL_R},
        '{COL_G, COL_R, COL_B, COL_G},
        '{COL_G, COL_B, COL_R, COL_G},
        '{COL_C, COL_M, COL_Y, COL_G},
        '{COL_M, COL_C, COL_G, COL_Y},
        '{COL_Y, COL_G, COL_C, COL_M},
        '{COL_G, COL_Y, COL_M, COL_C}
    };

    typedef struct packed {
        logic [PATTERN_BITS-1:0] pattern;
        logic                    row_par;
        logic                    col_par;
        logic                    border;
    } t_mosaic_ctl;

endpackage

@@ design/nndm_pix_if.sv @@
// raw sample channel and rgb pixel channel, valid/ready handshake
// depends on nndm_pkg
interface nndm_pix_if import nndm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] sample;
    logic                frame_start;

    modport source (output valid, sample, frame_start, input ready);
    modport sink   (input valid, sample, frame_start, output ready);
endinterface

interface nndm_rgb_if import nndm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                border;

    modport source (output valid, red, green, blue, border, input ready);
    modport sink   (input valid, red, green, blue, border, output ready);
endinterface

@@ design/nndm_color.sv @@
// color reconstruction from the 2x2 window for bayer and cmyg mosaics
// depends on nndm_pkg
module nndm_color import nndm_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  t_mosaic_ctl            i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_cur,
    input  logic [SAMPLE_BITS-1:0] i_left,
    input  logic [SAMPLE_BITS-1:0] i_up,
    input  logic [SAMPLE_BITS-1:0] i_up_left,
    output logic [SAMPLE_BITS-1:0] o_red,
    output logic [SAMPLE_BITS-1:0] o_green,
    output logic [SAMPLE_BITS-1:0] o_blue
);

    t_color                 c_cur, c_left, c_up, c_up_left;
    logic [SAMPLE_BITS-1:0] val [6];
    logic [SAMPLE_BITS:0]   sum_ym, sum_mc;

    assign c_cur     = PATTERN_MAP[i_ctl.pattern][{i_ctl.row_par, i_ctl.col_par}];
    assign c_left    = PATTERN_MAP[i_ctl.pattern][{i_ctl.row_par, ~i_ctl.col_par}];
    assign c_up      = PATTERN_MAP[i_ctl.pattern][{~i_ctl.row_par, i_ctl.col_par}];
    assign c_up_left = PATTERN_MAP[i_ctl.pattern][{~i_ctl.row_par, ~i_ctl.col_par}];

    // current wins, then left, then up, then up-left
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            priority if (c_cur == t_color'(3'(k))) begin
                val[k] = i_cur;
            end else if (c_left == t_color'(3'(k))) begin
                val[k] = i_left;
            end else if (c_up == t_color'(3'(k))) begin
                val[k] = i_up;
            end else if (c_up_left == t_color'(3'(k))) begin
                val[k] = i_up_left;
            end else begin
                val[k] = '0;
            end
        end
    end

    assign sum_ym = {1'b0, val[COL_Y]} + {1'b0, val[COL_M]};
    assign sum_mc = {1'b0, val[COL_M]} + {1'b0, val[COL_C]};

    always_comb begin
        priority if (i_ctl.border) begin
            o_red   = '0;
            o_green = '0;
            o_blue  = '0;
        end else if (i_ctl.pattern[PATTERN_BITS-1]) begin
            o_red   = sum_ym[SAMPLE_BITS:1];
            o_green = val[COL_G];
            o_blue  = sum_mc[SAMPLE_BITS:1];
        end else begin
            o_red   = val[COL_R];
            o_green = val[COL_G];
            o_blue  = val[COL_B];
        end
    end

endmodule

@@ design/nearest_neighbour_demosaic.sv @@
// nearest neighbor demosaic top level: one rgb pixel per raw sample
// a sample passes the window registers, then the output register, to pixel valid
// one sample per cycle while unstalled; line memory read and written once per sample
// synchronous active-low reset clears the control path, registers return to
// pattern 0 and line width 640, the line memory is not cleared
// depends on nndm_pkg, nndm_pix_if, nndm_rgb_if, nndm_color
module nearest_neighbour_demosaic import nndm_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    nndm_pix_if.sink                 i_pix,
    nndm_rgb_if.source               o_rgb,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW      = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_W = (LINE_WIDTH_BITS > EW) ? LINE_WIDTH_BITS : EW;

    // config registers
    logic [PATTERN_BITS-1:0]    r_pattern;
    logic [LINE_WIDTH_BITS-1:0] r_line_width;
    logic                       cfg_wr;
    t_reg_sel                   cfg_sel;

    // line position state
    logic [ADDR_W-1:0]  r_col;
    logic               r_row_par;
    logic               r_first_row;
    logic [ADDR_W-1:0]  col_start, col, n_col;
    logic [WIDTH_W-1:0] eff_width, lw_ext, col_inc;
    logic               rp_eff, first_eff, wrap, n_row_par, n_first_row;

    // line memory
    logic [SAMPLE_BITS-1:0] r_line_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] cur;

    // window stage
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_cur, r_s1_left, r_s1_up, r_s1_up_left;
    logic                   r_s1_rp, r_s1_cp, r_s1_border;
    logic                   acc_in, s1_adv;
    t_mosaic_ctl            s1_ctl;
    logic [SAMPLE_BITS-1:0] red, green, blue;

    // output stage
    logic                r_out_valid;
    logic [PIX_BITS-1:0] r_red, r_green, r_blue;
    logic                r_out_border;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_sel = t_reg_sel'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= '0;
            r_line_width <= LINE_WIDTH_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_PATTERN:    r_pattern    <= pwdata[PATTERN_BITS-1:0];
                REG_LINE_WIDTH: r_line_width <= pwdata[LINE_WIDTH_BITS-1:0];
                default:        r_pattern    <= r_pattern;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_PATTERN:    prdata = APB_DATA_BITS'(r_pattern);
            REG_LINE_WIDTH: prdata = APB_DATA_BITS'(r_line_width);
            default:        prdata = '0;
        endcase
    end

    // handshake
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rgb.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign acc_in      = i_pix.valid && i_pix.ready;
    assign cur         = i_pix.sample[SAMPLE_BITS-1:0];

    // line position
    assign lw_ext = WIDTH_W'(r_line_width);

    always_comb begin
        priority if (lw_ext < WIDTH_W'(MIN_WIDTH)) begin
            eff_width = WIDTH_W'(MIN_WIDTH);
        end else if (lw_ext > WIDTH_W'(MAX_WIDTH)) begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_width = lw_ext;
        end
    end

    assign col_start   = i_pix.frame_start ? '0 : r_col;
    assign rp_eff      = i_pix.frame_start ? 1'b0 : r_row_par;
    assign first_eff   = i_pix.frame_start || r_first_row;
    assign col         = (WIDTH_W'(col_start) >= eff_width) ? '0 : col_start;
    assign col_inc     = WIDTH_W'(col) + WIDTH_W'(1);
    assign wrap        = col_inc >= eff_width;
    assign n_col       = wrap ? '0 : col_inc[ADDR_W-1:0];
    assign n_row_par   = wrap ? ~rp_eff : rp_eff;
    assign n_first_row = wrap ? 1'b0 : first_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row_par   <= 1'b0;
            r_first_row <= 1'b1;
        end else if (acc_in) begin
            r_col       <= n_col;
            r_row_par   <= n_row_par;
            r_first_row <= n_first_row;
        end
    end

    // line memory, read old value and write new sample at the same column
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_line_mem[col] <= cur;
            r_s1_up         <= r_line_mem[col];
        end
    end

    // window registers hold the last accepted sample and its left, up and up-left neighbours
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_cur     <= cur;
            r_s1_left    <= r_s1_cur;
            r_s1_up_left <= r_s1_up;
            r_s1_rp      <= rp_eff;
            r_s1_cp      <= col[0];
            r_s1_border  <= first_eff || (col == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_in) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign s1_ctl = '{pattern: r_pattern, row_par: r_s1_rp, col_par: r_s1_cp,
                      border: r_s1_border};

    nndm_color #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_color (
        .i_ctl     (s1_ctl),
        .i_cur     (r_s1_cur),
        .i_left    (r_s1_left),
        .i_up      (r_s1_up),
        .i_up_left (r_s1_up_left),
        .o_red     (red),
        .o_green   (green),
        .o_blue    (blue)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_red        <= PIX_BITS'(red);
            r_green      <= PIX_BITS'(green);
            r_blue       <= PIX_BITS'(blue);
            r_out_border <= r_s1_border;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rgb.valid  = r_out_valid;
    assign o_rgb.red    = r_red;
    assign o_rgb.green  = r_green;
    assign o_rgb.blue   = r_blue;
    assign o_rgb.border = r_out_border;

endmodule

@@ design/nndm_checker.sv @@
// port-level checks for the nearest neighbor demosaic, with bind to the top level
// depends on nndm_pkg and nearest_neighbour_demosaic
module nndm_checker import nndm_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [PIX_BITS-1:0]      i_red,
    input logic [PIX_BITS-1:0]      i_green,
    input logic [PIX_BITS-1:0]      i_blue,
    input logic                     i_border,
    input logic                     i_psel,
    input logic                     i_penable,
    input logic                     i_pwrite,
    input logic [APB_ADDR_BITS-1:0] i_paddr,
    input logic [APB_DATA_BITS-1:0] i_pwdata,
    input logic [APB_DATA_BITS-1:0] i_prdata,
    input logic                     i_pready
);

    logic cfg_wr_width;

    assign cfg_wr_width = i_psel && i_penable && i_pwrite && i_pready
                          && (i_paddr[2] == REG_LINE_WIDTH);

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready dropped");

    a_out_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("pixel valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red)
            && $stable(i_green) && $stable(i_blue) && $stable(i_border))
        else $error("stalled pixel request changed");

    a_border_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_border |-> (i_red == '0) && (i_green == '0) && (i_blue == '0))
        else $error("border pixel not black");

    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(cfg_wr_width) && (i_paddr[2] == REG_LINE_WIDTH)
            |-> i_prdata[LINE_WIDTH_BITS-1:0] == $past(i_pwdata[LINE_WIDTH_BITS-1:0]))
        else $error("line width readback mismatch");

endmodule

bind nearest_neighbour_demosaic nndm_checker u_nndm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue),
    .i_border    (o_rgb.border),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata),
    .i_pready    (pready)
);

@@ verif/nndm_checker.sv @@
// checker for the nearest neighbor demosaic: follows register writes on the apb port,
// predicts one rgb pixel per accepted sample request and compares pixels in order
// depends on nndm_pkg, nndm_pix_if, nndm_rgb_if
module nndm_tb_checker import nndm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    nndm_pix_if                      i_pix,
    nndm_rgb_if                      i_rgb,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic                     i_pready,
    input  logic [APB_ADDR_BITS-1:0] i_paddr,
    input  logic [APB_DATA_BITS-1:0] i_pwdata,
    output int                       o_pending,
    output int                       o_failures
);

    typedef struct packed {
        logic [PIX_BITS-1:0] red;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] blue;
        logic                border;
    } t_pixel;

    // filter color at {row parity, column parity}
    localparam t_color MOSAIC_COLOR [8][4] = '{
        '{COL_R, COL_G, COL_G, COL_B},
        '{COL_B, COL_G, COL_G, COL_R},
        '{COL_G, COL_R, COL_B, COL_G},
        '{COL_G, COL_B, COL_R, COL_G},
        '{COL_C, COL_M, COL_Y, COL_G},
        '{COL_M, COL_C, COL_G, COL_Y},
        '{COL_Y, COL_G, COL_C, COL_M},
        '{COL_G, COL_Y, COL_M, COL_C}
    };

    logic [PATTERN_BITS-1:0]    cur_pattern;
    logic [LINE_WIDTH_BITS-1:0] cur_line_width;
    logic [PIX_BITS-1:0]        line_mem [DEF_MAX_WIDTH];
    logic [PIX_BITS-1:0]        left_px;
    logic [PIX_BITS-1:0]        up_left_px;
    int unsigned                col_cnt;
    logic                       row_odd;
    logic                       in_first_row;
    t_pixel                     pixels_due [$];
    t_pixel                     seen_px;
    t_pixel                     due_px;

    function automatic t_pixel demosaic_pixel(logic [PIX_BITS-1:0] cur, logic new_frame);
        int unsigned         width;
        int unsigned         col;
        int                  k;
        logic [PIX_BITS-1:0] up;
        logic [PIX_BITS-1:0] chan [6];
        logic [PIX_BITS-1:0] win_val [4];
        logic [1:0]          win_pos [4];
        t_pixel              px;

        width = cur_line_width;
        if (width < MIN_WIDTH) width = MIN_WIDTH;
        if (width > DEF_MAX_WIDTH) width = DEF_MAX_WIDTH;
        if (new_frame) begin
            col_cnt      = 0;
            row_odd      = 1'b0;
            in_first_row = 1'b1;
        end
        // a narrower width ends the line at once
        if (col_cnt >= width) col_cnt = 0;
        col = col_cnt;
        up  = line_mem[col];

        px        = '0;
        px.border = in_first_row || col == 0;
        if (!px.border) begin
            chan    = '{default: '0};
            win_val = '{cur, left_px, up, up_left_px};
            win_pos = '{{row_odd, col[0]}, {row_odd, ~col[0]},
                        {~row_odd, col[0]}, {~row_odd, ~col[0]}};
            // far corner first so that current, then left, wins a shared color
            for (k = 3; k >= 0; k--) chan[MOSAIC_COLOR[cur_pattern][win_pos[k]]] = win_val[k];
            if (!cur_pattern[2]) begin
                px.red   = chan[COL_R];
                px.green = chan[COL_G];
                px.blue  = chan[COL_B];
            end else begin
                px.red   = PIX_BITS'(({1'b0, chan[COL_Y]} + {1'b0, chan[COL_M]}) >> 1);
                px.green = chan[COL_G];
                px.blue  = PIX_BITS'(({1'b0, chan[COL_M]} + {1'b0, chan[COL_C]}) >> 1);
            end
        end

        up_left_px    = up;
        line_mem[col] = cur;
        left_px       = cur;
        col_cnt       = col + 1;
        if (col_cnt >= width) begin
            col_cnt      = 0;
            row_odd      = ~row_odd;
            in_first_row = 1'b0;
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_pattern    = '0;
            cur_line_width = LINE_WIDTH_RESET;
            left_px        = '0;
            up_left_px     = '0;
            col_cnt        = 0;
            row_odd        = 1'b0;
            in_first_row   = 1'b1;
            pixels_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_sel'(i_paddr[2]))
                    REG_PATTERN:    cur_pattern    = i_pwdata[PATTERN_BITS-1:0];
                    REG_LINE_WIDTH: cur_line_width = i_pwdata[LINE_WIDTH_BITS-1:0];
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                pixels_due.push_back(demosaic_pixel(i_pix.sample, i_pix.frame_start));
            end
            if (i_rgb.valid && i_rgb.ready) begin
                seen_px = {i_rgb.red, i_rgb.green, i_rgb.blue, i_rgb.border};
                if (pixels_due.size() == 0) begin
                    if (o_failures < 10) begin
                        $display("%0t unexpected pixel: r %h g %h b %h border %b", $time,
                                 seen_px.red, seen_px.green, seen_px.blue, seen_px.border);
                    end
                    o_failures++;
                end else begin
                    due_px = pixels_due.pop_front();
                    if (seen_px !== due_px) begin
                        if (o_failures < 10) begin
                            $display("%0t pixel mismatch: expected r %h g %h b %h border %b",
                                     $time, due_px.red, due_px.green, due_px.blue,
                                     due_px.border);
                            $display("%0t                 got      r %h g %h b %h border %b",
                                     $time, seen_px.red, seen_px.green, seen_px.blue,
                                     seen_px.border);
                        end
                        o_failures++;
                    end
                end
            end
        end
        o_pending = pixels_due.size();
    end

endmodule

@@ verif/tb_nearest_neighbour_demosaic.sv @@
// testbench top for the nearest neighbor demosaic: resets once, programs pattern and
// line width over apb, streams raw samples with random gaps and stalls, gives the verdict
// depends on nndm_pkg, nndm_pix_if, nndm_rgb_if, nndm_tb_checker, nearest_neighbour_demosaic
module tb_nearest_neighbour_demosaic;
    import nndm_pkg::*;

    localparam int                      RANDOM_SAMPLES = 860;
    localparam logic [PATTERN_BITS-1:0] PAT_RGGB       = 3'd0;
    localparam logic [PATTERN_BITS-1:0] PAT_CMYG       = 3'd4;
    localparam logic [PATTERN_BITS-1:0] PAT_GYMC       = 3'd7;
    localparam logic [PIX_BITS-1:0]     FULL_SCALE     = '1;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    int                       pixels_owed;
    int                       fail_total;
    int                       tx_gap_max;
    int                       rx_gap_max;
    int unsigned              frame_width;
    int                       random_sent;

    nndm_pix_if pix_ch ();
    nndm_rgb_if rgb_ch ();

    nearest_neighbour_demosaic uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_rgb   (rgb_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nndm_tb_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .i_rgb      (rgb_ch),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_pending  (pixels_owed),
        .o_failures (fail_total)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic set_mode(input logic [PATTERN_BITS-1:0] pat,
                            input logic [LINE_WIDTH_BITS-1:0] width);
        int                       r;
        t_reg_sel                 sel;
        logic [APB_DATA_BITS-1:0] word;

        for (r = 0; r < 2; r++) begin
            sel  = (r == 0) ? REG_PATTERN : REG_LINE_WIDTH;
            word = $urandom;
            if (sel == REG_PATTERN) word[PATTERN_BITS-1:0] = pat;
            else word[LINE_WIDTH_BITS-1:0] = width;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_ADDR_BITS'({sel, 2'b00});
            pwdata  <= word;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input logic [PIX_BITS-1:0] value, input logic new_frame);
        int gap;

        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.sample      <= value;
        pix_ch.frame_start <= new_frame;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
    endtask

    task automatic drain_pixels();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pixels_owed != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int lines, input int extra,
                             input logic [PATTERN_BITS-1:0] pat,
                             input logic [LINE_WIDTH_BITS-1:0] width, input bit pause_inside);
        int unsigned         eff;
        int                  count;
        int                  pause_at;
        int                  k;
        bit                  restart;
        logic [PIX_BITS-1:0] value;

        eff = width < MIN_WIDTH ? MIN_WIDTH : (width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width);
        count = lines * eff + extra;
        set_mode(pat, width);
        // a wider line must open a new frame so that no unwritten store entry is read
        restart     = eff > frame_width || $urandom_range(0, 1) == 0;
        frame_width = eff;
        pause_at    = pause_inside ? $urandom_range(1, count - 1) : -1;
        for (k = 0; k < count; k++) begin
            if (k == pause_at) drain_pixels();
            case ($urandom_range(0, 7))
                0:       value = '0;
                1:       value = FULL_SCALE;
                default: value = PIX_BITS'($urandom);
            endcase
            send_sample(value, (k == 0 && restart) || $urandom_range(0, 39) == 0);
        end
        random_sent += count;
        drain_pixels();
    endtask

    initial begin
        int stall;

        rgb_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, rx_gap_max);
            if (stall > 0) begin
                rgb_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rgb_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rgb_ch.valid && rgb_ch.ready));
        end
    end

    initial begin
        #5_000_000;
        $display("** nearest_neighbour_demosaic: FAILED **");
        $finish;
    end

    initial begin
        int                         phase;
        int                         k;
        logic [LINE_WIDTH_BITS-1:0] width;

        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.sample      <= '0;
        pix_ch.frame_start <= 1'b0;
        tx_gap_max  = 4;
        rx_gap_max  = 4;
        frame_width = 0;
        random_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // width below the minimum, full-scale and zero samples
        set_mode(PAT_RGGB, 13'd1);
        for (k = 0; k < 6; k++) send_sample(k[0] ? FULL_SCALE : '0, k == 0);
        drain_pixels();

        // odd width, cmyg sums at full scale, frame start in mid line
        set_mode(PAT_CMYG, 13'd3);
        for (k = 0; k < 9; k++) send_sample(k == 4 ? '0 : FULL_SCALE, k == 0 || k == 7);
        drain_pixels();

        // narrower width cuts the running line short
        set_mode(PAT_GYMC, 13'd8);
        for (k = 0; k < 10; k++) send_sample(PIX_BITS'(k * 'h1111), k == 0);
        drain_pixels();
        set_mode(PAT_GYMC, 13'd2);
        for (k = 0; k < 4; k++) send_sample(~PIX_BITS'(k * 'h1111), 1'b0);
        drain_pixels();
        frame_width = 2;

        for (phase = 0; random_sent < RANDOM_SAMPLES; phase++) begin
            case ($urandom_range(0, 19))
                0:       width = LINE_WIDTH_BITS'($urandom_range(0, 1));
                1, 2:    width = LINE_WIDTH_BITS'(2 * $urandom_range(1, 7) + 1);
                3, 4, 5: width = LINE_WIDTH_BITS'($urandom_range(16, 64));
                default: width = LINE_WIDTH_BITS'(2 * $urandom_range(1, 6));
            endcase
            tx_gap_max = $urandom_range(0, 3) == 0 ? 0 : 4;
            rx_gap_max = $urandom_range(0, 3) == 0 ? 0 : 4;
            run_phase(2, $urandom_range(4, 40),
                      phase < 8 ? PATTERN_BITS'(phase) : PATTERN_BITS'($urandom_range(0, 7)),
                      width, phase % 5 == 2);
        end

        // width above the store size acts as the full store
        tx_gap_max = 4;
        rx_gap_max = 4;
        run_phase(0, 40, PATTERN_BITS'($urandom_range(0, 7)), '1, 1'b0);

        repeat (8) @(posedge i_clk);
        if (fail_total == 0 && pixels_owed == 0) begin
            $display("** nearest_neighbour_demosaic: PASSED **");
        end else begin
            $display("** nearest_neighbour_demosaic: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/nndm_pkg.sv
design/nndm_pix_if.sv
design/nndm_color.sv
design/nearest_neighbour_demosaic.sv
design/nndm_checker.sv
verif/nndm_checker.sv
verif/tb_nearest_neighbour_demosaic.sv
